### rtl/pwdf_pkg.sv
// Shared types, codes and reset constants for the pointer/window drag/focus block.
// No dependencies.
package pwdf_pkg;

    localparam int WINDOW_COUNT_DEF = 2;
    localparam int DAMAGE_DEPTH     = 6;

    localparam logic [1:0] CMD_MOUSE = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    localparam logic KIND_DAMAGE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_MAGIC = 1'b1;

    localparam logic [2:0] CFG_DISPLAY_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_DISPLAY_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_CURSOR_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_CURSOR_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_EXPECTED_MAGIC = 3'd4;
    localparam logic [2:0] CFG_LEFT_MASK      = 3'd5;

    localparam logic [12:0] DISP_W_RST  = 13'd640;
    localparam logic [12:0] DISP_H_RST  = 13'd480;
    localparam logic [6:0]  CUR_W_RST   = 7'd16;
    localparam logic [6:0]  CUR_H_RST   = 7'd16;
    localparam logic [11:0] CUR_COL_RST = 12'd230;
    localparam logic [11:0] CUR_ROW_RST = 12'd210;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [12:0] w;
        logic [12:0] h;
    } rect_t;

    typedef struct packed {
        rect_t      r;
        logic [7:0] key;
    } win_entry_t;

    function automatic win_entry_t init_entry(int unsigned i);
        win_entry_t e;
        e = '0;
        case (i)
            0: e.r = '{x: 12'd100, y: 12'd100, w: 13'd200, h: 13'd160};
            1: e.r = '{x: 12'd220, y: 12'd200, w: 13'd320, h: 13'd240};
            default: e.r = '0;
        endcase
        return e;
    endfunction

endpackage

### rtl/pwdf_win_store.sv
// Window table: one write port, one registered read port, reset values via valid bits.
// Depends on pwdf_pkg.
module pwdf_win_store #(
    parameter int WINDOW_COUNT = pwdf_pkg::WINDOW_COUNT_DEF,
    parameter int IDX_W        = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [IDX_W-1:0]        rd_idx,
    output pwdf_pkg::win_entry_t    rd_data,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_idx,
    input  pwdf_pkg::win_entry_t    wr_data
);

    pwdf_pkg::win_entry_t mem_reg [WINDOW_COUNT];
    logic [WINDOW_COUNT-1:0] vld_reg;
    pwdf_pkg::win_entry_t rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_idx] <= wr_data;
        end
        rd_reg <= vld_reg[rd_idx] ? mem_reg[rd_idx] : pwdf_pkg::init_entry(int'(rd_idx));
    end

    assign rd_data = rd_reg;

endmodule

### rtl/pointer_window_drag_focus_top.sv
// Pointer/window drag/focus block: one item at a time, damage beats then one status beat.
// Flow: bad magic, unknown command or key with no focus go straight to the status beat;
// key and load read-modify-write the window table; mouse moves the cursor, drags a window
// and, on a left press, scans the window table for a hit.
// Throughput: one item per pass; hit test reads the window table one slot at a time.
// Reset: synchronous aresetn clears control, cursor to 230,210, no focus or drag,
// window table reads its reset contents at once. Depends on pwdf_pkg, pwdf_win_store.
module pointer_window_drag_focus_top #(
    parameter int WINDOW_COUNT = pwdf_pkg::WINDOW_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_packet_magic,
    input  logic signed [15:0] s_move_dx,
    input  logic signed [15:0] s_move_dy,
    input  logic [7:0]  s_button_bits,
    input  logic [7:0]  s_key_byte,
    input  logic        s_load_index,
    input  logic [11:0] s_load_x,
    input  logic [11:0] s_load_y,
    input  logic [12:0] s_load_w,
    input  logic [12:0] s_load_h,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [11:0] m_damage_x,
    output logic [11:0] m_damage_y,
    output logic [12:0] m_damage_w,
    output logic [12:0] m_damage_h,
    output logic        m_status,
    output logic [11:0] m_pointer_x,
    output logic [11:0] m_pointer_y,
    output logic signed [1:0] m_focus_index,
    output logic signed [1:0] m_drag_index,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;
    localparam logic [IDX_W:0] WC = (IDX_W+1)'(WINDOW_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MOVE, S_DRAG, S_CUR, S_PRESS, S_SCAN_RD, S_SCAN,
        S_HIT, S_FOC, S_NEW, S_RMW_RD, S_RMW_WR, S_EMIT
    } state_t;

    state_t state_reg;

    logic [12:0] disp_w_reg, disp_h_reg;
    logic [6:0]  cur_w_reg, cur_h_reg;
    logic [31:0] magic_reg;
    logic [7:0]  lmask_reg;

    logic [11:0] col_reg, row_reg;
    logic [7:0]  held_reg;
    logic        foc_vld_reg, drag_vld_reg, hit_vld_reg;
    logic [IDX_W-1:0] foc_idx_reg, drag_idx_reg, hit_idx_reg, scan_idx_reg;
    logic [11:0] grab_x_reg, grab_y_reg;
    pwdf_pkg::rect_t hit_rect_reg;

    logic [1:0]  cmd_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic [7:0]  btn_reg, key_reg;
    logic        lidx_reg;
    pwdf_pkg::rect_t load_rect_reg;
    logic [12:0] dw_reg, dh_reg;
    logic        status_reg;

    pwdf_pkg::rect_t dbuf_reg [pwdf_pkg::DAMAGE_DEPTH];
    logic [2:0]  dcnt_reg, ecnt_reg;

    logic [IDX_W-1:0] rd_idx, wr_idx;
    logic        wr_en;
    pwdf_pkg::win_entry_t rd_data, wr_data;

    pwdf_win_store #(.WINDOW_COUNT(WINDOW_COUNT), .IDX_W(IDX_W)) u_store (
        .aclk, .aresetn, .rd_idx, .rd_data, .wr_en, .wr_idx, .wr_data
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // cursor motion and clamp
    logic signed [17:0] sum_x, sum_y;
    logic [11:0] dwm1, dhm1, nx, ny;
    logic moved;
    assign dwm1  = 12'(dw_reg - 13'd1);
    assign dhm1  = 12'(dh_reg - 13'd1);
    assign sum_x = $signed({6'b0, col_reg}) + 18'(dx_reg);
    assign sum_y = $signed({6'b0, row_reg}) - 18'(dy_reg);
    assign nx = (sum_x < 0) ? 12'd0 :
                (sum_x > $signed({6'b0, dwm1})) ? dwm1 : sum_x[11:0];
    assign ny = (sum_y < 0) ? 12'd0 :
                (sum_y > $signed({6'b0, dhm1})) ? dhm1 : sum_y[11:0];
    assign moved = ((dx_reg != 16'sd0) || (dy_reg != 16'sd0)) &&
                   ((nx != col_reg) || (ny != row_reg));

    logic prev_left, is_left;
    assign prev_left = |(held_reg & lmask_reg);
    assign is_left   = |(btn_reg & lmask_reg);

    // drag clamp
    logic signed [13:0] mx_raw, my_raw;
    logic [11:0] mx, my, nl, nt;
    logic signed [12:0] tl, tt;
    assign mx_raw = $signed({1'b0, dw_reg}) - $signed({1'b0, rd_data.r.w});
    assign my_raw = $signed({1'b0, dh_reg}) - $signed({1'b0, rd_data.r.h});
    assign mx = (mx_raw < 0) ? 12'd0 : (mx_raw > 14'sd4095) ? 12'd4095 : mx_raw[11:0];
    assign my = (my_raw < 0) ? 12'd0 : (my_raw > 14'sd4095) ? 12'd4095 : my_raw[11:0];
    assign tl = $signed({1'b0, col_reg}) - $signed({1'b0, grab_x_reg});
    assign tt = $signed({1'b0, row_reg}) - $signed({1'b0, grab_y_reg});
    assign nl = (tl < 0) ? 12'd0 : (tl > $signed({1'b0, mx})) ? mx : tl[11:0];
    assign nt = (tt < 0) ? 12'd0 : (tt > $signed({1'b0, my})) ? my : tt[11:0];

    // hit test on the slot just read
    logic hit;
    assign hit = (col_reg >= rd_data.r.x) && (row_reg >= rd_data.r.y) &&
                 ({2'b0, col_reg} < ({2'b0, rd_data.r.x} + {1'b0, rd_data.r.w})) &&
                 ({2'b0, row_reg} < ({2'b0, rd_data.r.y} + {1'b0, rd_data.r.h}));

    logic foc_change;
    assign foc_change = (hit_vld_reg != foc_vld_reg) ||
                        (hit_vld_reg && (hit_idx_reg != foc_idx_reg));

    pwdf_pkg::rect_t cur_rect;
    assign cur_rect = '{x: col_reg, y: row_reg, w: {6'b0, cur_w_reg}, h: {6'b0, cur_h_reg}};

    always_comb begin
        rd_idx  = '0;
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = rd_data;
        case (state_reg)
            S_MOVE:    rd_idx = drag_idx_reg;
            S_SCAN_RD: rd_idx = scan_idx_reg;
            S_HIT:     rd_idx = foc_idx_reg;
            S_RMW_RD:  rd_idx = (cmd_reg == pwdf_pkg::CMD_LOAD) ? IDX_W'(lidx_reg) : foc_idx_reg;
            S_DRAG: begin
                wr_en        = 1'b1;
                wr_idx       = drag_idx_reg;
                wr_data.r.x  = nl;
                wr_data.r.y  = nt;
            end
            S_RMW_WR: begin
                wr_en = 1'b1;
                if (cmd_reg == pwdf_pkg::CMD_LOAD) begin
                    wr_idx    = IDX_W'(lidx_reg);
                    wr_data.r = load_rect_reg;
                end else begin
                    wr_idx      = foc_idx_reg;
                    wr_data.key = key_reg;
                end
            end
            default: ;
        endcase
    end

    logic [IDX_W+1:0] foc_ext, drag_ext;
    assign foc_ext  = {2'b00, foc_idx_reg};
    assign drag_ext = {2'b00, drag_idx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            disp_w_reg   <= pwdf_pkg::DISP_W_RST;
            disp_h_reg   <= pwdf_pkg::DISP_H_RST;
            cur_w_reg    <= pwdf_pkg::CUR_W_RST;
            cur_h_reg    <= pwdf_pkg::CUR_H_RST;
            magic_reg    <= '0;
            lmask_reg    <= 8'd1;
            col_reg      <= pwdf_pkg::CUR_COL_RST;
            row_reg      <= pwdf_pkg::CUR_ROW_RST;
            held_reg     <= '0;
            foc_vld_reg  <= 1'b0;
            drag_vld_reg <= 1'b0;
            foc_idx_reg  <= '0;
            drag_idx_reg <= '0;
            grab_x_reg   <= '0;
            grab_y_reg   <= '0;
            m_valid      <= 1'b0;
            dcnt_reg     <= '0;
            ecnt_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    pwdf_pkg::CFG_DISPLAY_WIDTH:  disp_w_reg <= cfg_data[12:0];
                    pwdf_pkg::CFG_DISPLAY_HEIGHT: disp_h_reg <= cfg_data[12:0];
                    pwdf_pkg::CFG_CURSOR_WIDTH:   cur_w_reg  <= cfg_data[6:0];
                    pwdf_pkg::CFG_CURSOR_HEIGHT:  cur_h_reg  <= cfg_data[6:0];
                    pwdf_pkg::CFG_EXPECTED_MAGIC: magic_reg  <= cfg_data;
                    pwdf_pkg::CFG_LEFT_MASK:      lmask_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready && (state_reg != S_EMIT)) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg       <= s_command;
                        dx_reg        <= s_move_dx;
                        dy_reg        <= s_move_dy;
                        btn_reg       <= s_button_bits;
                        key_reg       <= s_key_byte;
                        lidx_reg      <= s_load_index;
                        load_rect_reg <= '{x: s_load_x, y: s_load_y, w: s_load_w, h: s_load_h};
                        dw_reg <= (disp_w_reg == 13'd0) ? 13'd1 :
                                  (disp_w_reg > 13'd4096) ? 13'd4096 : disp_w_reg;
                        dh_reg <= (disp_h_reg == 13'd0) ? 13'd1 :
                                  (disp_h_reg > 13'd4096) ? 13'd4096 : disp_h_reg;
                        dcnt_reg   <= '0;
                        ecnt_reg   <= '0;
                        status_reg <= pwdf_pkg::STATUS_OK;
                        case (s_command)
                            pwdf_pkg::CMD_MOUSE: begin
                                if (s_packet_magic != magic_reg) begin
                                    status_reg <= pwdf_pkg::STATUS_BAD_MAGIC;
                                    state_reg  <= S_EMIT;
                                end else begin
                                    state_reg <= S_MOVE;
                                end
                            end
                            pwdf_pkg::CMD_KEY:
                                state_reg <= foc_vld_reg ? S_RMW_RD : S_EMIT;
                            pwdf_pkg::CMD_LOAD:
                                state_reg <= ({{IDX_W{1'b0}}, s_load_index} < WC) ?
                                             S_RMW_RD : S_EMIT;
                            default: state_reg <= S_EMIT;
                        endcase
                    end
                end
                S_MOVE: begin
                    if (moved) begin
                        dbuf_reg[dcnt_reg] <= cur_rect;
                        dcnt_reg <= dcnt_reg + 3'd1;
                        col_reg  <= nx;
                        row_reg  <= ny;
                        state_reg <= (drag_vld_reg && (prev_left || is_left)) ? S_DRAG : S_CUR;
                    end else begin
                        state_reg <= S_PRESS;
                    end
                end
                S_DRAG: begin
                    if ((nl != rd_data.r.x) || (nt != rd_data.r.y)) begin
                        dbuf_reg[dcnt_reg] <= rd_data.r;
                        dbuf_reg[dcnt_reg + 3'd1] <= '{x: nl, y: nt, w: rd_data.r.w,
                                                       h: rd_data.r.h};
                        dcnt_reg <= dcnt_reg + 3'd2;
                    end
                    state_reg <= S_CUR;
                end
                S_CUR: begin
                    dbuf_reg[dcnt_reg] <= cur_rect;
                    dcnt_reg  <= dcnt_reg + 3'd1;
                    state_reg <= S_PRESS;
                end
                S_PRESS: begin
                    held_reg <= btn_reg;
                    if (!prev_left && is_left) begin
                        scan_idx_reg <= LAST_IDX;
                        state_reg    <= S_SCAN_RD;
                    end else begin
                        if (prev_left && !is_left) begin
                            drag_vld_reg <= 1'b0;
                        end
                        state_reg <= S_EMIT;
                    end
                end
                S_SCAN_RD: state_reg <= S_SCAN;
                S_SCAN: begin
                    hit_idx_reg  <= scan_idx_reg;
                    hit_rect_reg <= rd_data.r;
                    if (hit) begin
                        hit_vld_reg <= 1'b1;
                        state_reg   <= S_HIT;
                    end else if (scan_idx_reg == '0) begin
                        hit_vld_reg <= 1'b0;
                        state_reg   <= S_HIT;
                    end else begin
                        scan_idx_reg <= scan_idx_reg - 1'b1;
                        state_reg    <= S_SCAN_RD;
                    end
                end
                S_HIT: begin
                    if (foc_change) begin
                        state_reg <= foc_vld_reg ? S_FOC : S_NEW;
                    end else begin
                        drag_vld_reg <= hit_vld_reg;
                        drag_idx_reg <= hit_idx_reg;
                        grab_x_reg   <= col_reg - hit_rect_reg.x;
                        grab_y_reg   <= row_reg - hit_rect_reg.y;
                        state_reg    <= S_EMIT;
                    end
                end
                S_FOC: begin
                    dbuf_reg[dcnt_reg] <= rd_data.r;
                    dcnt_reg  <= dcnt_reg + 3'd1;
                    state_reg <= S_NEW;
                end
                S_NEW: begin
                    if (hit_vld_reg) begin
                        dbuf_reg[dcnt_reg] <= hit_rect_reg;
                        dcnt_reg <= dcnt_reg + 3'd1;
                    end
                    foc_vld_reg  <= hit_vld_reg;
                    foc_idx_reg  <= hit_idx_reg;
                    drag_vld_reg <= hit_vld_reg;
                    drag_idx_reg <= hit_idx_reg;
                    grab_x_reg   <= col_reg - hit_rect_reg.x;
                    grab_y_reg   <= row_reg - hit_rect_reg.y;
                    state_reg    <= S_EMIT;
                end
                S_RMW_RD: state_reg <= S_RMW_WR;
                S_RMW_WR: state_reg <= S_EMIT;
                S_EMIT: begin
                    if (!m_valid || m_ready) begin
                        m_valid       <= 1'b1;
                        m_pointer_x   <= col_reg;
                        m_pointer_y   <= row_reg;
                        m_focus_index <= foc_vld_reg ? foc_ext[1:0] : 2'sb11;
                        m_drag_index  <= drag_vld_reg ? drag_ext[1:0] : 2'sb11;
                        if (ecnt_reg < dcnt_reg) begin
                            m_kind     <= pwdf_pkg::KIND_DAMAGE;
                            m_damage_x <= dbuf_reg[ecnt_reg].x;
                            m_damage_y <= dbuf_reg[ecnt_reg].y;
                            m_damage_w <= dbuf_reg[ecnt_reg].w;
                            m_damage_h <= dbuf_reg[ecnt_reg].h;
                            m_status   <= pwdf_pkg::STATUS_OK;
                            m_last     <= 1'b0;
                            ecnt_reg   <= ecnt_reg + 3'd1;
                        end else begin
                            m_kind     <= pwdf_pkg::KIND_STATUS;
                            m_damage_x <= '0;
                            m_damage_y <= '0;
                            m_damage_w <= '0;
                            m_damage_h <= '0;
                            m_status   <= status_reg;
                            m_last     <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (ecnt_reg <= dcnt_reg) && (dcnt_reg <= 3'd6))
        else $error("damage count overrun");

    a_idle_status: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_IDLE) && ($past(state_reg) == S_EMIT)) |-> (m_valid && m_last))
        else $error("item closed without status beat");

    a_bad_magic_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == pwdf_pkg::STATUS_BAD_MAGIC)) |->
        (m_last && (m_kind == pwdf_pkg::KIND_STATUS)))
        else $error("bad magic beat with damage");

endmodule
